[src/dhl_pkg.sv]
// dhl_pkg: shared types and constants of the dh link chain transform
// no dependencies
`default_nettype none
package dhl_pkg;

  localparam int CordicSteps = 30;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  typedef struct packed {
    logic               restart;
    logic signed [23:0] link_length;
    logic signed [23:0] link_offset;
    logic        [15:0] theta;
    logic        [15:0] alpha;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } qhead_t;

  function automatic logic [29:0] atan_val(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'h20000000;
      5'd1:  v = 30'h12E4051E;
      5'd2:  v = 30'h09FB385B;
      5'd3:  v = 30'h051111D4;
      5'd4:  v = 30'h028B0D43;
      5'd5:  v = 30'h0145D7E1;
      5'd6:  v = 30'h00A2F61E;
      5'd7:  v = 30'h00517C55;
      5'd8:  v = 30'h0028BE53;
      5'd9:  v = 30'h00145F2F;
      5'd10: v = 30'h000A2F98;
      5'd11: v = 30'h000517CC;
      5'd12: v = 30'h00028BE6;
      5'd13: v = 30'h000145F3;
      5'd14: v = 30'h0000A2FA;
      5'd15: v = 30'h0000517D;
      5'd16: v = 30'h000028BE;
      5'd17: v = 30'h0000145F;
      5'd18: v = 30'h00000A30;
      5'd19: v = 30'h00000518;
      5'd20: v = 30'h0000028C;
      5'd21: v = 30'h00000146;
      5'd22: v = 30'h000000A3;
      5'd23: v = 30'h00000051;
      5'd24: v = 30'h00000029;
      5'd25: v = 30'h00000014;
      5'd26: v = 30'h0000000A;
      5'd27: v = 30'h00000005;
      5'd28: v = 30'h00000003;
      5'd29: v = 30'h00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[src/dhl_in_if.sv]
// dhl_in_if: link request channel, valid/ready with link fields
// no dependencies
`default_nettype none
interface dhl_in_if;
  logic               valid;
  logic               ready;
  logic               restart;
  logic signed [23:0] link_length;
  logic signed [15:0] link_twist;
  logic signed [23:0] link_offset;
  logic signed [15:0] joint_angle;
  logic signed [15:0] joint_command;

  modport source (output valid, restart, link_length, link_twist, link_offset,
                  joint_angle, joint_command, input ready);
  modport sink (input valid, restart, link_length, link_twist, link_offset,
                joint_angle, joint_command, output ready);
endinterface
`default_nettype wire

[src/dhl_out_if.sv]
// dhl_out_if: transform result channel, valid/ready with 3x4 matrix fields
// no dependencies
`default_nettype none
interface dhl_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rot_00, rot_01, rot_02;
  logic signed [15:0] rot_10, rot_11, rot_12;
  logic signed [15:0] rot_20, rot_21, rot_22;
  logic signed [31:0] pos_x, pos_y, pos_z;

  modport source (output valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                  rot_20, rot_21, rot_22, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                rot_20, rot_21, rot_22, pos_x, pos_y, pos_z, output ready);
endinterface
`default_nettype wire

[src/dhl_front.sv]
// dhl_front: accepts link requests, forms the wrapped joint angle, two-entry queue
// depends on dhl_pkg, dhl_in_if
`default_nettype none
module dhl_front #(
  parameter int ANGLE_BITS = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  dhl_in_if.sink              in_i,
  input  wire logic           pop_i,
  output dhl_pkg::qhead_t     head_o
);

  localparam int ClrBits = (ANGLE_BITS < 16) ? (16 - ANGLE_BITS) : 0;
  localparam logic [15:0] AngMask = 16'hFFFF << ClrBits;

  dhl_pkg::job_t ent_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;
  logic          push;
  logic          pop;
  dhl_pkg::job_t job;

  assign in_i.ready = (cnt_q != 2'd2);
  assign push = in_i.valid && in_i.ready;
  assign pop  = pop_i && (cnt_q != 2'd0);

  always_comb begin
    job.restart     = in_i.restart;
    job.link_length = in_i.link_length;
    job.link_offset = in_i.link_offset;
    job.theta       = (in_i.joint_angle + in_i.joint_command) & AngMask;
    job.alpha       = in_i.link_twist & AngMask;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      if (push && !pop) cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.job   = ent_q[rd_q];

endmodule
`default_nettype wire

[src/dhl_back.sv]
// dhl_back: two iterative cordic lanes, link matrix build and chain compose
// depends on dhl_pkg, dhl_out_if
`default_nettype none
module dhl_back #(
  parameter int ROT_FRAC_BITS = 14
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire dhl_pkg::qhead_t head_i,
  output logic                 pop_o,
  dhl_out_if.source            out_o
);

  localparam int LW  = ROT_FRAC_BITS + 3;
  localparam int PLW = 26;
  localparam int OW  = (LW > PLW) ? LW : PLW;
  localparam int PW  = 16 + OW;
  localparam int AW  = PW + 2;
  localparam int S0  = 30 - ROT_FRAC_BITS;
  localparam int S1  = 60 - ROT_FRAC_BITS;
  localparam logic signed [32:0] H0 = (33'sd1 <<< S0) >>> 1;
  localparam logic signed [64:0] H1 = (65'sd1 <<< S1) >>> 1;
  localparam logic signed [64:0] H2 = 65'sd1 <<< 29;
  localparam logic signed [AW-1:0] HR = (AW'(1) <<< ROT_FRAC_BITS) >>> 1;
  localparam logic signed [15:0] One =
      (ROT_FRAC_BITS >= 15) ? 16'sh7FFF : 16'(1 << ROT_FRAC_BITS);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StCordic = 3'd1;
  localparam logic [2:0] StFix    = 3'd2;
  localparam logic [2:0] StLmul   = 3'd3;
  localparam logic [2:0] StComp   = 3'd4;
  localparam logic [2:0] StWait   = 3'd5;

  logic [2:0] state_q;
  logic [4:0] cnt_q;
  logic       tagv_q;
  logic       ov_q;

  logic signed [23:0] a_q, d_q;
  logic signed [33:0] x_q [2], y_q [2], z_q [2];
  logic               flip_q [2];
  logic signed [31:0] ct_q, st_q, ca_q, sa_q;
  logic signed [LW-1:0]  l_q [9];
  logic signed [PLW-1:0] lp_q [3];
  logic signed [63:0] prod_q;
  logic signed [PW-1:0] p_q [3];
  logic [3:0] tag_q;
  logic signed [15:0] cr_q [9], rn_q [9], ro_q [9];
  logic signed [31:0] cp_q [3], pn_q [3], po_q [3];

  logic signed [33:0] xn [2], yn [2], zn [2];
  logic signed [33:0] z0 [2];
  logic               f0 [2];
  logic [15:0]        ang [2];
  logic signed [31:0] ma, mb;
  logic signed [64:0] r1s, r2s;
  logic signed [LW-1:0]  r1;
  logic signed [PLW-1:0] r2;
  logic [1:0] cr_r, cc_c;
  logic signed [15:0]   crow [3];
  logic signed [OW-1:0] opnd [3];
  logic signed [AW-1:0] acc, vsh;
  logic signed [AW:0]   psum;
  logic signed [15:0]   rsat;
  logic signed [31:0]   psat;
  logic signed [31:0]   cpr;
  logic [3:0]           widx;
  logic                 load;

  function automatic logic signed [LW-1:0] rnd0(input logic signed [31:0] v);
    logic signed [32:0] t;
    t = (33'(v) + H0) >>> S0;
    return LW'(t);
  endfunction

  // cordic lanes: 0 = joint angle, 1 = twist
  always_comb begin
    ang[0] = head_i.job.theta;
    ang[1] = head_i.job.alpha;
    for (int j = 0; j < 2; j++) begin
      f0[j] = (ang[j][15:14] == 2'b01) || (ang[j][15:14] == 2'b10);
      z0[j] = 34'(signed'({f0[j] ? (ang[j] ^ 16'h8000) : ang[j], 16'h0000}));
      if (!z_q[j][33]) begin
        xn[j] = x_q[j] - (y_q[j] >>> cnt_q);
        yn[j] = y_q[j] + (x_q[j] >>> cnt_q);
        zn[j] = z_q[j] - 34'(dhl_pkg::atan_val(cnt_q));
      end else begin
        xn[j] = x_q[j] + (y_q[j] >>> cnt_q);
        yn[j] = y_q[j] - (x_q[j] >>> cnt_q);
        zn[j] = z_q[j] + 34'(dhl_pkg::atan_val(cnt_q));
      end
    end
  end

  // link matrix multiplier operands
  always_comb begin
    case (cnt_q[2:0])
      3'd0: begin ma = st_q; mb = ca_q; end
      3'd1: begin ma = st_q; mb = sa_q; end
      3'd2: begin ma = ct_q; mb = ca_q; end
      3'd3: begin ma = ct_q; mb = sa_q; end
      3'd4: begin ma = 32'(a_q); mb = ct_q; end
      3'd5: begin ma = 32'(a_q); mb = st_q; end
      default: begin ma = '0; mb = '0; end
    endcase
    r1s = (65'(prod_q) + H1) >>> S1;
    r2s = (65'(prod_q) + H2) >>> 30;
    r1  = LW'(r1s);
    r2  = PLW'(r2s);
  end

  // compose operand selection
  always_comb begin
    cr_r = cnt_q[3:2];
    cc_c = cnt_q[1:0];
    for (int k = 0; k < 3; k++) begin
      case (cr_r)
        2'd0:    crow[k] = cr_q[k];
        2'd1:    crow[k] = cr_q[3 + k];
        default: crow[k] = cr_q[6 + k];
      endcase
      case (cc_c)
        2'd0:    opnd[k] = OW'(l_q[k * 3]);
        2'd1:    opnd[k] = OW'(l_q[k * 3 + 1]);
        2'd2:    opnd[k] = OW'(l_q[k * 3 + 2]);
        default: opnd[k] = OW'(lp_q[k]);
      endcase
    end
    acc  = AW'(p_q[0]) + AW'(p_q[1]) + AW'(p_q[2]);
    vsh  = (acc + HR) >>> ROT_FRAC_BITS;
    case (tag_q[3:2])
      2'd0:    cpr = cp_q[0];
      2'd1:    cpr = cp_q[1];
      default: cpr = cp_q[2];
    endcase
    psum = (AW + 1)'(vsh) + (AW + 1)'(cpr);
    if (vsh > AW'(32767)) rsat = 16'sh7FFF;
    else if (vsh < -AW'(32768)) rsat = -16'sh8000;
    else rsat = 16'(vsh);
    if (psum > (AW + 1)'(32'sh7FFFFFFF)) psat = 32'sh7FFFFFFF;
    else if (psum < (AW + 1)'(-33'sh80000000)) psat = -32'sh80000000;
    else psat = 32'(psum);
    widx = {2'b00, tag_q[3:2]} * 4'd3 + {2'b00, tag_q[1:0]};
  end

  assign pop_o = (state_q == StIdle) && head_i.valid;
  assign load  = (state_q == StWait) && (!ov_q || out_o.ready);

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        a_q <= head_i.job.link_length;
        d_q <= head_i.job.link_offset;
        for (int j = 0; j < 2; j++) begin
          x_q[j]    <= dhl_pkg::CordicGain;
          y_q[j]    <= '0;
          z_q[j]    <= z0[j];
          flip_q[j] <= f0[j];
        end
      end
      StCordic: begin
        for (int j = 0; j < 2; j++) begin
          x_q[j] <= xn[j];
          y_q[j] <= yn[j];
          z_q[j] <= zn[j];
        end
      end
      StFix: begin
        ct_q <= 32'(flip_q[0] ? -x_q[0] : x_q[0]);
        st_q <= 32'(flip_q[0] ? -y_q[0] : y_q[0]);
        ca_q <= 32'(flip_q[1] ? -x_q[1] : x_q[1]);
        sa_q <= 32'(flip_q[1] ? -y_q[1] : y_q[1]);
      end
      StLmul: begin
        if (cnt_q == 5'd0) begin
          l_q[0]  <= rnd0(ct_q);
          l_q[3]  <= rnd0(st_q);
          l_q[6]  <= '0;
          l_q[7]  <= rnd0(sa_q);
          l_q[8]  <= rnd0(ca_q);
          lp_q[2] <= PLW'(d_q);
        end
        prod_q <= ma * mb;
        case (cnt_q[2:0])
          3'd1: l_q[1]  <= -r1;
          3'd2: l_q[2]  <= r1;
          3'd3: l_q[4]  <= r1;
          3'd4: l_q[5]  <= -r1;
          3'd5: lp_q[0] <= r2;
          3'd6: lp_q[1] <= r2;
          default: ;
        endcase
      end
      StComp: begin
        for (int k = 0; k < 3; k++) begin
          p_q[k] <= PW'(crow[k]) * PW'(opnd[k]);
        end
        tag_q <= cnt_q[3:0];
        if (tagv_q) begin
          if (tag_q[1:0] == 2'd3) pn_q[tag_q[3:2]] <= psat;
          else rn_q[widx] <= rsat;
        end
      end
      default: ;
    endcase
    if (load) begin
      ro_q <= rn_q;
      po_q <= pn_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      tagv_q  <= 1'b0;
      ov_q    <= 1'b0;
      for (int k = 0; k < 9; k++) cr_q[k] <= (k % 4 == 0) ? One : 16'sd0;
      for (int k = 0; k < 3; k++) cp_q[k] <= '0;
    end else begin
      if (load) ov_q <= 1'b1;
      else if (out_o.ready) ov_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (head_i.valid) begin
            state_q <= StCordic;
            cnt_q   <= '0;
            if (head_i.job.restart) begin
              for (int k = 0; k < 9; k++) cr_q[k] <= (k % 4 == 0) ? One : 16'sd0;
              for (int k = 0; k < 3; k++) cp_q[k] <= '0;
            end
          end
        end
        StCordic: begin
          if (cnt_q == 5'(dhl_pkg::CordicSteps - 1)) begin
            state_q <= StFix;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        StFix: begin
          state_q <= StLmul;
        end
        StLmul: begin
          if (cnt_q == 5'd6) begin
            state_q <= StComp;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        StComp: begin
          tagv_q <= (cnt_q < 5'd12);
          if (cnt_q == 5'd12) begin
            state_q <= StWait;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        StWait: begin
          if (load) begin
            state_q <= StIdle;
            cr_q    <= rn_q;
            cp_q    <= pn_q;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_o.valid  = ov_q;
  assign out_o.rot_00 = ro_q[0];
  assign out_o.rot_01 = ro_q[1];
  assign out_o.rot_02 = ro_q[2];
  assign out_o.rot_10 = ro_q[3];
  assign out_o.rot_11 = ro_q[4];
  assign out_o.rot_12 = ro_q[5];
  assign out_o.rot_20 = ro_q[6];
  assign out_o.rot_21 = ro_q[7];
  assign out_o.rot_22 = ro_q[8];
  assign out_o.pos_x  = po_q[0];
  assign out_o.pos_y  = po_q[1];
  assign out_o.pos_z  = po_q[2];

endmodule
`default_nettype wire

[src/dh_link_chain_transform.sv]
// dh_link_chain_transform: each link passes through 30 steps of the two parallel cordic
// lanes, 7 of the shared link multiplier and 13 of the three-multiplier compose pipeline;
// a new link is not started until the result register has taken the previous result
// a two-entry queue takes further requests meanwhile; the result register holds one
// reset is asynchronous active low: queue empty, chain transform identity, position zero
// depends on dhl_pkg, dhl_in_if, dhl_out_if, dhl_front, dhl_back
`default_nettype none
module dh_link_chain_transform #(
  parameter int ANGLE_BITS    = 16,
  parameter int ROT_FRAC_BITS = 14
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dhl_in_if.sink    in_i,
  dhl_out_if.source out_o
);

  dhl_pkg::qhead_t head;
  logic            pop;

  dhl_front #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .pop_i (pop),
    .head_o(head)
  );

  dhl_back #(
    .ROT_FRAC_BITS(ROT_FRAC_BITS)
  ) u_back (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .head_i(head),
    .pop_o (pop),
    .out_o (out_o)
  );

endmodule
`default_nettype wire

[test/tb_chain_pkg.sv]
// tb_chain_pkg: request and transform types used by the dh link chain testbench
// no dependencies
`default_nettype none
package tb_chain_pkg;

  typedef struct packed {
    logic               restart;
    logic signed [23:0] link_length;
    logic signed [15:0] link_twist;
    logic signed [23:0] link_offset;
    logic signed [15:0] joint_angle;
    logic signed [15:0] joint_command;
  } link_req_t;

  typedef struct packed {
    logic signed [15:0] rot_00, rot_01, rot_02;
    logic signed [31:0] pos_x;
    logic signed [15:0] rot_10, rot_11, rot_12;
    logic signed [31:0] pos_y;
    logic signed [15:0] rot_20, rot_21, rot_22;
    logic signed [31:0] pos_z;
  } frame_t;

endpackage
`default_nettype wire

[test/tb.sv]
// tb: self-checking testbench of dh_link_chain_transform with a fixed-point chain predictor
// depends on dhl_in_if, dhl_out_if, tb_chain_pkg and the block's rtl
`default_nettype none
module tb;

  localparam int AngleBits = 16;
  localparam int RotFrac   = 14;
  localparam int MaxWait   = 18;
  localparam longint CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  longint cycles = 0;
  int errors = 0;
  int sent = 0;
  int received = 0;
  int restarts = 0;
  int saturated = 0;

  dhl_in_if  link_ch ();
  dhl_out_if frame_ch ();

  dh_link_chain_transform #(.ANGLE_BITS(AngleBits), .ROT_FRAC_BITS(RotFrac)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (link_ch.sink),
    .out_o (frame_ch.source)
  );

  tb_chain_pkg::frame_t expected_frames[$];
  longint chain_rot[9];
  longint chain_pos[3];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("dh_link_chain_transform: mismatch");
      $finish;
    end
  end

  function automatic longint shift_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  task automatic sin_cos(input logic [15:0] raw, output longint c, output longint s);
    logic [31:0] ang;
    logic [31:0] keep;
    logic flip;
    longint x, y, z, t;
    longint atan_tab[30] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43,
      'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F,
      'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2FA,
      'h0000517D, 'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
      'h0000028C, 'h00000146, 'h000000A3, 'h00000051, 'h00000029,
      'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001};
    keep = ~((32'd1 << (32 - AngleBits)) - 32'd1);
    ang = {raw, 16'd0} & keep;
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    if (flip) ang = ang - 32'h80000000;
    z = longint'(signed'(ang));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        t = x - shift_floor(y, i);
        y = y + shift_floor(x, i);
        z -= atan_tab[i];
      end else begin
        t = x + shift_floor(y, i);
        y = y - shift_floor(x, i);
        z += atan_tab[i];
      end
      x = t;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic reset_chain();
    foreach (chain_rot[i]) chain_rot[i] = 0;
    chain_rot[0] = clamp(longint'(1) << RotFrac, 16);
    chain_rot[4] = chain_rot[0];
    chain_rot[8] = chain_rot[0];
    foreach (chain_pos[i]) chain_pos[i] = 0;
  endtask

  task automatic predict_link(input tb_chain_pkg::link_req_t req);
    longint ct, st, ca, sa, acc, sum;
    longint lk[9];
    longint lp[3];
    longint nr[9];
    longint np[3];
    logic [15:0] th;
    tb_chain_pkg::frame_t f;
    if (req.restart) reset_chain();
    th = req.joint_angle + req.joint_command;
    sin_cos(th, ct, st);
    sin_cos(req.link_twist, ca, sa);
    lk[0] = round_shift(ct, 30 - RotFrac);
    lk[1] = -round_shift(st * ca, 60 - RotFrac);
    lk[2] = round_shift(st * sa, 60 - RotFrac);
    lk[3] = round_shift(st, 30 - RotFrac);
    lk[4] = round_shift(ct * ca, 60 - RotFrac);
    lk[5] = -round_shift(ct * sa, 60 - RotFrac);
    lk[6] = 0;
    lk[7] = round_shift(sa, 30 - RotFrac);
    lk[8] = round_shift(ca, 30 - RotFrac);
    lp[0] = round_shift(longint'(req.link_length) * ct, 30);
    lp[1] = round_shift(longint'(req.link_length) * st, 30);
    lp[2] = longint'(req.link_offset);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += chain_rot[r*3+k] * lk[k*3+c];
        nr[r*3+c] = clamp(round_shift(acc, RotFrac), 16);
      end
      acc = 0;
      for (int k = 0; k < 3; k++) acc += chain_rot[r*3+k] * lp[k];
      sum = round_shift(acc, RotFrac) + chain_pos[r];
      np[r] = clamp(sum, 32);
      if (np[r] != sum) saturated++;
    end
    foreach (nr[i]) chain_rot[i] = nr[i];
    foreach (np[i]) chain_pos[i] = np[i];
    f.rot_00 = 16'(nr[0]); f.rot_01 = 16'(nr[1]); f.rot_02 = 16'(nr[2]);
    f.pos_x  = 32'(np[0]);
    f.rot_10 = 16'(nr[3]); f.rot_11 = 16'(nr[4]); f.rot_12 = 16'(nr[5]);
    f.pos_y  = 32'(np[1]);
    f.rot_20 = 16'(nr[6]); f.rot_21 = 16'(nr[7]); f.rot_22 = 16'(nr[8]);
    f.pos_z  = 32'(np[2]);
    expected_frames.insert(expected_frames.size(), f);
  endtask

  task automatic send_link(input tb_chain_pkg::link_req_t req);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, MaxWait);
    if (gap != 0) begin
      link_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    link_ch.valid         <= 1'b1;
    link_ch.restart       <= req.restart;
    link_ch.link_length   <= req.link_length;
    link_ch.link_twist    <= req.link_twist;
    link_ch.link_offset   <= req.link_offset;
    link_ch.joint_angle   <= req.joint_angle;
    link_ch.joint_command <= req.joint_command;
    do @(posedge clk_i); while (!link_ch.ready);
    predict_link(req);
    sent++;
    if (req.restart) restarts++;
    @(negedge clk_i);
  endtask

  initial begin
    int stall;
    frame_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, MaxWait);
      if (stall != 0) begin
        frame_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      frame_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!frame_ch.valid);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    tb_chain_pkg::frame_t f;
    if (rst_ni && frame_ch.valid && frame_ch.ready) begin
      received++;
      if (expected_frames.size() == 0) begin
        $error("unexpected transform result");
        errors++;
      end else begin
        f = expected_frames.pop_front();
        if (frame_ch.rot_00 !== f.rot_00) begin
          $error("rot_00 exp %0d got %0d", f.rot_00, frame_ch.rot_00); errors++; end
        if (frame_ch.rot_01 !== f.rot_01) begin
          $error("rot_01 exp %0d got %0d", f.rot_01, frame_ch.rot_01); errors++; end
        if (frame_ch.rot_02 !== f.rot_02) begin
          $error("rot_02 exp %0d got %0d", f.rot_02, frame_ch.rot_02); errors++; end
        if (frame_ch.pos_x !== f.pos_x) begin
          $error("pos_x exp %0d got %0d", f.pos_x, frame_ch.pos_x); errors++; end
        if (frame_ch.rot_10 !== f.rot_10) begin
          $error("rot_10 exp %0d got %0d", f.rot_10, frame_ch.rot_10); errors++; end
        if (frame_ch.rot_11 !== f.rot_11) begin
          $error("rot_11 exp %0d got %0d", f.rot_11, frame_ch.rot_11); errors++; end
        if (frame_ch.rot_12 !== f.rot_12) begin
          $error("rot_12 exp %0d got %0d", f.rot_12, frame_ch.rot_12); errors++; end
        if (frame_ch.pos_y !== f.pos_y) begin
          $error("pos_y exp %0d got %0d", f.pos_y, frame_ch.pos_y); errors++; end
        if (frame_ch.rot_20 !== f.rot_20) begin
          $error("rot_20 exp %0d got %0d", f.rot_20, frame_ch.rot_20); errors++; end
        if (frame_ch.rot_21 !== f.rot_21) begin
          $error("rot_21 exp %0d got %0d", f.rot_21, frame_ch.rot_21); errors++; end
        if (frame_ch.rot_22 !== f.rot_22) begin
          $error("rot_22 exp %0d got %0d", f.rot_22, frame_ch.rot_22); errors++; end
        if (frame_ch.pos_z !== f.pos_z) begin
          $error("pos_z exp %0d got %0d", f.pos_z, frame_ch.pos_z); errors++; end
      end
    end
  end

  function automatic tb_chain_pkg::link_req_t make_link(logic rs, int a, int tw, int d,
                                                        int th, int cmd);
    tb_chain_pkg::link_req_t r;
    r.restart = rs;
    r.link_length = 24'(a);
    r.link_twist = 16'(tw);
    r.link_offset = 24'(d);
    r.joint_angle = 16'(th);
    r.joint_command = 16'(cmd);
    return r;
  endfunction

  function automatic tb_chain_pkg::link_req_t random_link(int restart_odds);
    tb_chain_pkg::link_req_t r;
    r.restart = $urandom_range(0, restart_odds) == 0;
    case ($urandom_range(0, 3))
      0: r.link_length = 24'($urandom);
      1: r.link_length = 24'(int'($urandom_range(0, 8191)) - 4096);
      default: r.link_length = 24'(int'($urandom_range(0, 2000000)) - 1000000);
    endcase
    r.link_offset   = $urandom_range(0, 1) ? 24'($urandom) :
                                             24'(int'($urandom_range(0, 40000)) - 20000);
    r.link_twist    = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 3) << 14) :
                                                  16'($urandom);
    r.joint_angle   = 16'($urandom);
    r.joint_command = 16'($urandom);
    return r;
  endfunction

  task automatic test_field_extremes();
    send_link(make_link(1, 0, 0, 0, 0, 0));
    send_link(make_link(0, 8388607, 32767, 8388607, 32767, 32767));
    send_link(make_link(0, -8388608, -32768, -8388608, -32768, -32768));
    send_link(make_link(1, 4096, 16384, 4096, -16384, 0));
    send_link(make_link(0, -1, -1, -1, -1, -1));
    send_link(make_link(1, 1, 1, 1, 1, 1));
  endtask

  task automatic test_angle_wrap();
    send_link(make_link(1, 4096, 0, 0, 32767, 1));
    send_link(make_link(0, 4096, 0, 0, -32768, -1));
    send_link(make_link(0, 4096, 8192, 0, 30000, 30000));
    send_link(make_link(0, 4096, -8192, 0, -30000, -30000));
    send_link(make_link(0, 4096, 32767, 0, 16384, 16384));
  endtask

  task automatic test_position_saturation();
    send_link(make_link(1, 8388607, 0, 8388607, 0, 0));
    for (int i = 0; i < 8; i++)
      send_link(make_link(0, 8388607, 0, 8388607, 0, 0));
    send_link(make_link(1, -8388608, 0, -8388608, 0, 0));
    for (int i = 0; i < 5; i++)
      send_link(make_link(0, -8388608, 0, -8388608, 0, 0));
  endtask

  task automatic test_random_chains();
    for (int i = 0; i < 1075; i++)
      send_link(random_link($urandom_range(0, 1) ? 6 : 40));
  endtask

  initial begin
    link_ch.valid = 1'b0;
    link_ch.restart = 1'b0;
    link_ch.link_length = '0;
    link_ch.link_twist = '0;
    link_ch.link_offset = '0;
    link_ch.joint_angle = '0;
    link_ch.joint_command = '0;
    reset_chain();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_field_extremes();
    test_angle_wrap();
    test_position_saturation();
    test_random_chains();
    link_ch.valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("sent %0d links (%0d restarts), checked %0d transforms, %0d saturated positions",
             sent, restarts, received, saturated);
    if (errors == 0 && expected_frames.size() == 0) begin
      $display("dh_link_chain_transform: match");
    end else begin
      $display("dh_link_chain_transform: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
